/* rtl/vls_pkg.sv */
package vls_pkg;

   // One queued item, as classified by the front end.
   typedef struct packed {
      logic        is_vertex;
      logic [2:0]  slot;
      logic        is_point;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [30:0] radius;
      logic [23:0] rgb;
      logic [11:0] gain;
      logic [31:0] color;
   } item_type;

   // Uniform light factor, 0.1 in Q0.16.
   localparam logic [16:0] TENTH_Q16   = 17'd6554;
   // Saturation point of a channel sum, one in units of 1/(255*2^24).
   localparam logic [31:0] ONE_ADD     = 32'hFF00_0000;
   // Depth is |y|/1000, rounded half away from zero.
   localparam logic [31:0] DEPTH_ROUND = 32'd500;
   // Reciprocal of 1000 for 32-bit values: x/1000 == (x*0x10624DD3) >> 38.
   localparam logic [28:0] DEPTH_RECIP = 29'h1062_4DD3;
   // Reciprocal of 255 for 16-bit values: x/255 == (x*0x8081) >> 23.
   localparam logic [31:0] RECIP_255   = 32'h0000_8081;
   // Serial step counts.
   localparam logic [5:0]  DIV_STEPS   = 6'd48;
   localparam logic [5:0]  ROOT_STEPS  = 6'd32;

endpackage

/* rtl/vls_fifo.sv */
module vls_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   // Two-entry queue between the front end and the shading engine.
   logic [WIDTH-1:0] mem_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/vls_front.sv */
module vls_front #(
   parameter int MAX_LIGHTS = 8
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [2:0]        req_slot,
   input  logic              req_light_kind,
   input  logic [31:0]       req_pos_x,
   input  logic [31:0]       req_pos_y,
   input  logic [30:0]       req_radius,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic [11:0]       req_intensity,
   input  logic [31:0]       req_vertex_color,
   input  logic              queue_full,
   output logic              queue_push,
   output vls_pkg::item_type queue_item
);

   logic slot_in_table;
   logic transfer;

   // The queue holds items in order, so light writes never overtake vertices.
   assign req_stall = queue_full;
   assign transfer  = req_valid && !queue_full;

   // Light writes to a slot outside the table are dropped here.
   assign slot_in_table = ({3'd0, req_slot} < 6'(MAX_LIGHTS));
   assign queue_push    = transfer && (req_action || slot_in_table);

   // Pack the item for the shading engine.
   always_comb begin
      queue_item.is_vertex = req_action;
      queue_item.slot      = req_slot;
      queue_item.is_point  = req_light_kind;
      queue_item.pos_x     = req_pos_x;
      queue_item.pos_y     = req_pos_y;
      queue_item.radius    = req_radius;
      queue_item.rgb       = {req_blue, req_green, req_red};
      queue_item.gain      = req_intensity;
      queue_item.color     = req_vertex_color;
   end

endmodule

/* rtl/vls_back.sv */
module vls_back #(
   parameter int MAX_LIGHTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [3:0]        csr_active_lights,
   input  logic              queue_empty,
   input  vls_pkg::item_type queue_item,
   output logic              queue_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_shaded_color,
   output logic [22:0]       rsp_depth,
   output logic [31:0]       rsp_out_x,
   output logic [31:0]       rsp_out_y
);

   localparam int IDXW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int CNTW = IDXW + 1;

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_DEPTH   = 13'b0000000000010,
      S_LOAD    = 13'b0000000000100,
      S_SQUARE  = 13'b0000000001000,
      S_ROOTSET = 13'b0000000010000,
      S_ROOT    = 13'b0000000100000,
      S_FALL    = 13'b0000001000000,
      S_MUL1    = 13'b0000010000000,
      S_MUL2    = 13'b0000100000000,
      S_ACC     = 13'b0001000000000,
      S_BLEND   = 13'b0010000000000,
      S_SCALE   = 13'b0100000000000,
      S_OUT     = 13'b1000000000000
   } state_type;

   // Light table.
   logic [31:0] lx_ff    [MAX_LIGHTS];
   logic [31:0] ly_ff    [MAX_LIGHTS];
   logic [30:0] lr_ff    [MAX_LIGHTS];
   logic        lp_ff    [MAX_LIGHTS];
   logic [23:0] lrgb_ff  [MAX_LIGHTS];
   logic [11:0] gain_ff  [MAX_LIGHTS];

   state_type       state_ff, state_in;
   logic [3:0]      active_ff, active_in;
   logic [CNTW-1:0] n_ff, n_in, k_ff, k_in;
   logic [31:0]     vx_ff, vx_in, vy_ff, vy_in, color_ff, color_in;
   logic            neg_ff, neg_in;
   logic [22:0]     depth_ff, depth_in;
   logic [31:0]     dnum_ff, dnum_in;
   logic [47:0]     num_ff, num_in, quo_ff, quo_in;
   logic [30:0]     rem_ff, rem_in, den_ff, den_in;
   logic [5:0]      step_ff, step_in;
   logic [30:0]     r_ff, r_in, ax_ff, ax_in, ay_ff, ay_in;
   logic [61:0]     sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [62:0]     v_ff, v_in, bit_ff, bit_in;
   logic [63:0]     res_ff, res_in;
   logic [16:0]     f_ff, f_in;
   logic [19:0]     lgp_ff  [3];
   logic [19:0]     lgp_in  [3];
   logic [36:0]     prod_ff [3];
   logic [36:0]     prod_in [3];
   logic [31:0]     acc_ff  [3];
   logic [31:0]     acc_in  [3];
   logic [15:0]     t_ff    [3];
   logic [15:0]     t_in    [3];
   logic [31:0]     pack_ff, pack_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_color_ff, rsp_color_in;
   logic [22:0]     rsp_depth_ff, rsp_depth_in;
   logic [31:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic [IDXW-1:0] kidx;
   logic [IDXW-1:0] widx;
   logic            table_we;
   logic [31:0]     rem_sh;
   logic [32:0]     trial;
   logic            div_ge;
   logic [30:0]     rem_nx;
   logic [47:0]     quo_nx;
   logic [63:0]     root_sum;
   logic            root_take;
   logic [63:0]     res_nx;
   logic [32:0]     dx, dy, adx, ady;
   logic [30:0]     r_floor;
   logic [31:0]     vmag;
   logic [60:0]     depth_prod;
   logic [31:0]     root_dist;
   logic [37:0]     acc_sum;
   logic [39:0]     blend_prod;
   logic [31:0]     scale_prod;
   logic [7:0]      chan;
   logic [7:0]      chan_out;

   assign kidx     = k_ff[IDXW-1:0];
   assign widx     = IDXW'(queue_item.slot);
   assign queue_pop = (state_ff == S_IDLE) && !queue_empty;
   assign table_we  = queue_pop && !queue_item.is_vertex;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shaded_color = rsp_color_ff;
   assign rsp_depth        = rsp_depth_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;

   // One restoring division step for the falloff divide.
   assign rem_sh = {rem_ff, num_ff[47]};
   assign trial  = {1'b0, rem_sh} - {2'b00, den_ff};
   assign div_ge = !trial[32];
   assign rem_nx = div_ge ? trial[30:0] : rem_sh[30:0];
   assign quo_nx = {quo_ff[46:0], div_ge};

   // One integer square root step, one result bit per cycle.
   assign root_sum  = res_ff + {1'b0, bit_ff};
   assign root_take = ({1'b0, v_ff} >= root_sum);
   assign res_nx    = root_take ? ((res_ff >> 1) + {1'b0, bit_ff}) : (res_ff >> 1);
   assign root_dist = res_nx[31:0];

   // Vertex to light offsets.
   assign dx      = {vx_ff[31], vx_ff} - {lx_ff[kidx][31], lx_ff[kidx]};
   assign dy      = {vy_ff[31], vy_ff} - {ly_ff[kidx][31], ly_ff[kidx]};
   assign adx     = dx[32] ? (33'd0 - dx) : dx;
   assign ady     = dy[32] ? (33'd0 - dy) : dy;
   assign r_floor = (lr_ff[kidx] == 31'd0) ? 31'd1 : lr_ff[kidx];

   // Depth magnitude by reciprocal multiplication; the quotient is bits 60:38.
   assign vmag       = queue_item.pos_y[31] ? (32'd0 - queue_item.pos_y) : queue_item.pos_y;
   assign depth_prod = {29'd0, dnum_ff} * {32'd0, vls_pkg::DEPTH_RECIP};

   always_comb begin
      state_in     = state_ff;
      active_in    = csr_write_enable ? csr_active_lights : active_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      color_in     = color_ff;
      neg_in       = neg_ff;
      depth_in     = depth_ff;
      dnum_in      = dnum_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      step_in      = step_ff;
      r_in         = r_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      v_in         = v_ff;
      bit_in       = bit_ff;
      res_in       = res_ff;
      f_in         = f_ff;
      pack_in      = pack_ff;
      acc_sum      = 38'd0;
      blend_prod   = 40'd0;
      scale_prod   = 32'd0;
      chan         = 8'd0;
      chan_out     = 8'd0;
      for (int ch = 0; ch < 3; ch++) begin
         lgp_in[ch]  = lgp_ff[ch];
         prod_in[ch] = prod_ff[ch];
         acc_in[ch]  = acc_ff[ch];
         t_in[ch]    = t_ff[ch];
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      case (state_ff)
         S_IDLE: begin
            // Light items write the table in this cycle; vertices start the depth.
            if (queue_pop && queue_item.is_vertex) begin
               vx_in    = queue_item.pos_x;
               vy_in    = queue_item.pos_y;
               color_in = queue_item.color;
               neg_in   = !queue_item.pos_y[31] && (queue_item.pos_y != 32'd0);
               n_in     = (int'(active_ff) > MAX_LIGHTS) ? CNTW'(MAX_LIGHTS) :
                          CNTW'(active_ff);
               k_in     = '0;
               for (int ch = 0; ch < 3; ch++) begin
                  acc_in[ch] = 32'd0;
               end
               dnum_in  = vmag + vls_pkg::DEPTH_ROUND;
               state_in = S_DEPTH;
            end
         end
         S_DEPTH: begin
            depth_in = depth_prod[60:38];
            state_in = (n_ff == '0) ? S_BLEND : S_LOAD;
         end
         S_LOAD: begin
            // Classify the light: uniform, out of reach, or needing a distance.
            if (!lp_ff[kidx]) begin
               f_in     = vls_pkg::TENTH_Q16;
               state_in = S_MUL1;
            end else if (adx >= {2'b00, r_floor} || ady >= {2'b00, r_floor}) begin
               f_in     = 17'd0;
               state_in = S_MUL1;
            end else begin
               ax_in    = adx[30:0];
               ay_in    = ady[30:0];
               r_in     = r_floor;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            sqx_in   = {31'd0, ax_ff} * {31'd0, ax_ff};
            sqy_in   = {31'd0, ay_ff} * {31'd0, ay_ff};
            state_in = S_ROOTSET;
         end
         S_ROOTSET: begin
            v_in     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
            res_in   = 64'd0;
            bit_in   = {1'b1, 62'd0};
            step_in  = 6'd0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_take) begin
               v_in = v_ff - root_sum[62:0];
            end
            res_in  = res_nx;
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 6'd1;
            if (step_ff == vls_pkg::ROOT_STEPS - 6'd1) begin
               if (root_dist >= {1'b0, r_ff}) begin
                  f_in     = 17'd0;
                  state_in = S_MUL1;
               end else begin
                  num_in   = {1'b0, r_ff - root_dist[30:0], 16'd0};
                  den_in   = r_ff;
                  rem_in   = 31'd0;
                  quo_in   = 48'd0;
                  step_in  = 6'd0;
                  state_in = S_FALL;
               end
            end
         end
         S_FALL: begin
            num_in  = {num_ff[46:0], 1'b0};
            rem_in  = rem_nx;
            quo_in  = quo_nx;
            step_in = step_ff + 6'd1;
            if (step_ff == vls_pkg::DIV_STEPS - 6'd1) begin
               f_in     = quo_nx[16:0];
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            for (int ch = 0; ch < 3; ch++) begin
               lgp_in[ch] = {12'd0, lrgb_ff[kidx][8*ch +: 8]} * {8'd0, gain_ff[kidx]};
            end
            state_in = S_MUL2;
         end
         S_MUL2: begin
            for (int ch = 0; ch < 3; ch++) begin
               prod_in[ch] = {17'd0, lgp_ff[ch]} * {20'd0, f_ff};
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            // Saturating sum; every term is non-negative, so early clamping is exact.
            for (int ch = 0; ch < 3; ch++) begin
               acc_sum    = {6'd0, acc_ff[ch]} + {1'b0, prod_ff[ch]};
               acc_in[ch] = (acc_sum > {6'd0, vls_pkg::ONE_ADD}) ?
                            vls_pkg::ONE_ADD : acc_sum[31:0];
            end
            k_in     = k_ff + CNTW'(1);
            state_in = (k_in < n_ff) ? S_LOAD : S_BLEND;
         end
         S_BLEND: begin
            for (int ch = 0; ch < 3; ch++) begin
               chan       = color_ff[8*ch +: 8];
               blend_prod = {8'd0, acc_ff[ch]} * {32'd0, 8'd255 - chan};
               t_in[ch]   = blend_prod[39:24];
            end
            state_in = S_SCALE;
         end
         S_SCALE: begin
            // Depth takes the sign opposite to y.
            depth_in       = neg_ff ? (23'd0 - depth_ff) : depth_ff;
            pack_in[31:24] = color_ff[31:24];
            for (int ch = 0; ch < 3; ch++) begin
               chan       = color_ff[8*ch +: 8];
               scale_prod = {16'd0, t_ff[ch]} * vls_pkg::RECIP_255;
               chan_out   = chan + scale_prod[30:23];
               pack_in[8*ch +: 8] = chan_out;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = pack_ff;
               rsp_depth_in = depth_ff;
               rsp_x_in     = vx_ff;
               rsp_y_in     = vy_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      k_ff         <= k_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      color_ff     <= color_in;
      neg_ff       <= neg_in;
      depth_ff     <= depth_in;
      dnum_ff      <= dnum_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      step_ff      <= step_in;
      r_ff         <= r_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      v_ff         <= v_in;
      bit_ff       <= bit_in;
      res_ff       <= res_in;
      f_ff         <= f_in;
      pack_ff      <= pack_in;
      rsp_color_ff <= rsp_color_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      for (int ch = 0; ch < 3; ch++) begin
         lgp_ff[ch]  <= lgp_in[ch];
         prod_ff[ch] <= prod_in[ch];
         acc_ff[ch]  <= acc_in[ch];
         t_ff[ch]    <= t_in[ch];
      end
   end

   // Light table write, in queue order.
   always_ff @(posedge clock) begin
      if (table_we) begin
         lx_ff[widx]   <= queue_item.pos_x;
         ly_ff[widx]   <= queue_item.pos_y;
         lr_ff[widx]   <= queue_item.radius;
         lp_ff[widx]   <= queue_item.is_point;
         lrgb_ff[widx] <= queue_item.rgb;
         gain_ff[widx] <= queue_item.gain;
      end
   end

endmodule

/* rtl/vertex_light2d_shade.sv */
// Channel   | Handshake            | Carries
// ----------+----------------------+------------------------------------------
// req_      | req_valid/req_stall  | light slot write or vertex to shade
// rsp_      | rsp_valid/rsp_stall  | shaded colour, depth and position
// csr_      | csr_write_enable     | active_lights, written at once
//
// A light write reaches the table as it leaves the two-entry queue.
// A vertex runs the depth multiply and the blend and, per active light, the
// multiply-accumulate; point lights within reach on both axes also run the
// bit-serial square root, and those whose distance is under the radius the
// bit-serial divider.
// Reset is synchronous and clears the queue, the engine and active_lights.
// The queue keeps accepting while a result waits on rsp_stall, until it is full.
module vertex_light2d_shade #(
   parameter int MAX_LIGHTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_active_lights,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [2:0]  req_slot,
   input  logic        req_light_kind,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [30:0] req_radius,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [11:0] req_intensity,
   input  logic [31:0] req_vertex_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_shaded_color,
   output logic [22:0] rsp_depth,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y
);

   localparam int ITEM_W = $bits(vls_pkg::item_type);

   vls_pkg::item_type push_item;
   vls_pkg::item_type pop_item;
   logic              push, pop, full, empty;

   // Front end: accepts and classifies transfers.
   vls_front #(.MAX_LIGHTS(MAX_LIGHTS)) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_light_kind   (req_light_kind),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_radius       (req_radius),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_intensity    (req_intensity),
      .req_vertex_color (req_vertex_color),
      .queue_full       (full),
      .queue_push       (push),
      .queue_item       (push_item)
   );

   // Queue between the two halves.
   vls_fifo #(.WIDTH(ITEM_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_item),
      .pop       (pop),
      .pop_data  (pop_item),
      .full      (full),
      .empty     (empty)
   );

   // Shading engine with the light table.
   vls_back #(.MAX_LIGHTS(MAX_LIGHTS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_active_lights (csr_active_lights),
      .queue_empty       (empty),
      .queue_item        (pop_item),
      .queue_pop         (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_shaded_color  (rsp_shaded_color),
      .rsp_depth         (rsp_depth),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y)
   );

endmodule

/* rtl/vls_checker.sv */
module vls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [22:0] rsp_depth,
   input logic [31:0] rsp_out_y
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Depth stays within the range of y divided by 1000.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_depth) <= 23'sd2147484) &&
                    ($signed(rsp_depth) >= -23'sd2147484))
      else $error("depth out of range");

   // Depth has the sign opposite to y.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_y[31] |-> !rsp_depth[22])
      else $error("depth negative for negative y");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_y[31] |-> rsp_depth[22] || (rsp_depth == 23'd0))
      else $error("depth positive for positive y");

endmodule

bind vertex_light2d_shade vls_checker u_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   typedef enum bit {LIGHT_WRITE = 1'b0, VERTEX_SHADE = 1'b1} action_type;
   typedef enum bit {UNIFORM_LIGHT = 1'b0, POINT_LIGHT = 1'b1} kind_type;

   localparam int LIGHT_SLOTS = 8;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_ITEMS = 1800;

   typedef struct {
      action_type  action;
      logic [2:0]  slot;
      kind_type    kind;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [30:0] radius;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] intensity;
      logic [31:0] color;
   } shade_item_type;

   typedef struct {
      logic [31:0] color;
      logic [22:0] depth;
      logic [31:0] x;
      logic [31:0] y;
   } shade_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [3:0]  csr_active_lights = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [2:0]  req_slot = '0;
   logic        req_light_kind = 1'b0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [30:0] req_radius = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [11:0] req_intensity = '0;
   logic [31:0] req_vertex_color = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_shaded_color;
   logic [22:0] rsp_depth;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;

   vertex_light2d_shade dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_active_lights(csr_active_lights),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_slot(req_slot), .req_light_kind(req_light_kind),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_radius(req_radius),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .req_intensity(req_intensity), .req_vertex_color(req_vertex_color),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_shaded_color(rsp_shaded_color), .rsp_depth(rsp_depth),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y)
   );

   always #5 clock = ~clock;

   // Mirror of the light table and the active light count.
   logic [31:0] tbl_x [LIGHT_SLOTS];
   logic [31:0] tbl_y [LIGHT_SLOTS];
   logic [30:0] tbl_radius [LIGHT_SLOTS];
   kind_type    tbl_kind [LIGHT_SLOTS];
   logic [23:0] tbl_rgb [LIGHT_SLOTS];
   logic [11:0] tbl_gain [LIGHT_SLOTS];
   logic [3:0]  active_count = '0;

   shade_result_type pending_shades[$];
   int errors = 0;
   int burst_left = 0;
   bit hold_request = 1'b0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root = 0;
      longint unsigned step = 64'd1 << 62;
      while (step > v) step >>= 2;
      while (step != 0) begin
         if (v >= root + step) begin
            v = v - (root + step);
            root = (root >> 1) + step;
         end else begin
            root >>= 1;
         end
         step >>= 2;
      end
      return root;
   endfunction

   // Q1.16 weight of one light at a vertex position.
   function automatic longint unsigned light_weight(int k, longint vx, longint vy);
      longint unsigned r, ax, ay, root_dist;
      longint dx, dy;
      if (tbl_kind[k] == UNIFORM_LIGHT) return vls_pkg::TENTH_Q16;
      r = tbl_radius[k];
      if (r < 1) r = 1;
      dx = vx - longint'(signed'(tbl_x[k]));
      dy = vy - longint'(signed'(tbl_y[k]));
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      // Lights out of reach on either axis add nothing.
      if (ax >= r || ay >= r) return 0;
      root_dist = int_sqrt(ax * ax + ay * ay);
      if (root_dist >= r) return 0;
      return ((r - root_dist) << 16) / r;
   endfunction

   function automatic shade_result_type shade_vertex(shade_item_type it);
      shade_result_type res;
      longint unsigned sum [3];
      longint unsigned w, c, a, o, mag, q;
      longint vx, vy;
      int n;
      vx = longint'(signed'(it.pos_x));
      vy = longint'(signed'(it.pos_y));
      n = active_count > LIGHT_SLOTS ? LIGHT_SLOTS : active_count;
      res.color = it.color;
      if (n > 0) begin
         sum = '{0, 0, 0};
         for (int k = 0; k < n; k++) begin
            w = light_weight(k, vx, vy);
            for (int ch = 0; ch < 3; ch++)
               sum[ch] += longint'(tbl_rgb[k][8*ch +: 8]) * tbl_gain[k] * w;
         end
         // Clamp each channel sum to one and blend toward white.
         for (int ch = 0; ch < 3; ch++) begin
            c = it.color[8*ch +: 8];
            a = sum[ch] > vls_pkg::ONE_ADD ? vls_pkg::ONE_ADD : sum[ch];
            o = c + (a * (255 - c)) / vls_pkg::ONE_ADD;
            if (o > 255) o = 255;
            res.color[8*ch +: 8] = o[7:0];
         end
      end
      mag = vy < 0 ? -vy : vy;
      q = (mag + 500) / 1000;
      res.depth = vy > 0 ? 23'(-longint'(q)) : 23'(q);
      res.x = it.pos_x;
      res.y = it.pos_y;
      return res;
   endfunction

   function automatic void apply_item(shade_item_type it);
      if (it.action == LIGHT_WRITE) begin
         tbl_x[it.slot] = it.pos_x;
         tbl_y[it.slot] = it.pos_y;
         tbl_radius[it.slot] = it.radius;
         tbl_kind[it.slot] = it.kind;
         tbl_rgb[it.slot] = {it.blue, it.green, it.red};
         tbl_gain[it.slot] = it.intensity;
      end else begin
         pending_shades.push_back(shade_vertex(it));
      end
   endfunction

   function automatic shade_item_type random_fields();
      shade_item_type it;
      it.action = action_type'($urandom_range(0, 1));
      it.slot = 3'($urandom_range(0, 7));
      it.kind = kind_type'($urandom_range(0, 1));
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.radius = 31'($urandom);
      it.red = 8'($urandom);
      it.green = 8'($urandom);
      it.blue = 8'($urandom);
      it.intensity = 12'($urandom);
      it.color = $urandom;
      return it;
   endfunction

   function automatic shade_item_type light_item(int slot, kind_type kind, logic [31:0] x,
         logic [31:0] y, logic [30:0] r, logic [23:0] rgb, logic [11:0] gain);
      shade_item_type it = random_fields();
      it.action = LIGHT_WRITE;
      it.slot = 3'(slot);
      it.kind = kind;
      it.pos_x = x;
      it.pos_y = y;
      it.radius = r;
      {it.blue, it.green, it.red} = rgb;
      it.intensity = gain;
      return it;
   endfunction

   function automatic shade_item_type vertex_item(logic [31:0] x, logic [31:0] y,
         logic [31:0] color);
      shade_item_type it = random_fields();
      it.action = VERTEX_SHADE;
      it.pos_x = x;
      it.pos_y = y;
      it.color = color;
      return it;
   endfunction

   // Called just after a falling edge; returns just after a falling edge.
   task automatic send_item(shade_item_type it);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_action = it.action;
      req_slot = it.slot;
      req_light_kind = it.kind;
      req_pos_x = it.pos_x;
      req_pos_y = it.pos_y;
      req_radius = it.radius;
      req_red = it.red;
      req_green = it.green;
      req_blue = it.blue;
      req_intensity = it.intensity;
      req_vertex_color = it.color;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_item(it);
      @(negedge clock);
   endtask

   // Drain all expected shades, then let any queued light write finish.
   task automatic drain();
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_shades.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic set_active_lights(logic [3:0] count);
      drain();
      csr_active_lights = count;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      active_count = count;
   endtask

   // With no lights the vertex colour passes through.
   task automatic test_passthrough();
      set_active_lights(4'd0);
      send_item(vertex_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
      send_item(vertex_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
      send_item(vertex_item(32'd0, 32'd1500, 32'h80C0_4020));
      send_item(vertex_item(32'd1, 32'hFFFF_FA24, 32'h12345678));
   endtask

   // Fill every slot with extreme lights and shade against them.
   task automatic test_light_extremes();
      send_item(light_item(0, POINT_LIGHT, 0, 0, 31'd0, 24'hFFFFFF, 12'hFFF));
      send_item(light_item(1, POINT_LIGHT, 32'h8000_0000, 32'h7FFF_FFFF,
                           31'h7FFF_FFFF, 24'h0000FF, 12'h100));
      send_item(light_item(2, UNIFORM_LIGHT, 0, 0, 31'd5, 24'h00FF00, 12'hFFF));
      send_item(light_item(3, UNIFORM_LIGHT, 0, 0, 31'd5, 24'hFFFFFF, 12'd0));
      send_item(light_item(4, POINT_LIGHT, 32'h0001_0000, 32'h0001_0000,
                           31'h0004_0000, 24'hFF0000, 12'h800));
      send_item(light_item(5, POINT_LIGHT, 32'hFFFF_0000, 0, 31'h0001_0000,
                           24'h000000, 12'hFFF));
      send_item(light_item(6, POINT_LIGHT, 0, 32'h0002_0000, 31'h0000_8000,
                           24'h808080, 12'h0FF));
      send_item(light_item(7, UNIFORM_LIGHT, 32'h7FFF_FFFF, 32'h8000_0000,
                           31'd1, 24'h102030, 12'h001));
      set_active_lights(4'd8);
      send_item(vertex_item(0, 0, 32'hFF00_0000));
      send_item(vertex_item(32'h0001_0000, 32'h0001_0000, 32'h00FF_FFFF));
      send_item(vertex_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hA5A5_A5A5));
      // Inside both axis bounds but beyond the radius.
      send_item(vertex_item(32'h0004_3000, 32'h0004_3000, 32'h0000_0000));
      set_active_lights(4'd1);
      send_item(vertex_item(0, 0, 32'h0000_0000));
      send_item(vertex_item(1, 0, 32'h0000_0000));
   endtask

   // Counts above the table size act as a full table.
   task automatic test_too_many_lights();
      set_active_lights(4'd15);
      send_item(vertex_item(32'h0000_8000, 32'h0001_0000, 32'h4040_4040));
      set_active_lights(4'd9);
      send_item(vertex_item(32'hFFFF_8000, 0, 32'h0102_0304));
   endtask

   // Receiver holds off while the sender keeps offering items.
   task automatic test_back_pressure();
      set_active_lights(4'd2);
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++)
         send_item(vertex_item($urandom, $urandom, $urandom));
      drain();
   endtask

   task automatic test_random_traffic();
      shade_item_type it;
      logic [3:0] count;
      longint off_x, off_y, r;
      int k, phase, sent;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: count = 4'd0;
            1: count = 4'd15;
            2: count = 4'd8;
            3: count = 4'd1;
            default: count = 4'($urandom_range(0, 15));
         endcase
         set_active_lights(count);
         phase++;
         for (int i = $urandom_range(30, 120); i > 0 && sent < RANDOM_ITEMS; i--) begin
            it = random_fields();
            if ($urandom_range(0, 9) < 2) begin
               it.action = LIGHT_WRITE;
               // Mostly compact scenes with moderate radii.
               if ($urandom_range(0, 3) != 0) begin
                  it.pos_x = 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
                  it.pos_y = 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
                  it.radius = $urandom_range(0, 9) == 0 ? 31'd0 :
                              31'($urandom_range(1 << 12, 1 << 21));
               end
            end else begin
               it.action = VERTEX_SHADE;
               k = $urandom_range(0, LIGHT_SLOTS - 1);
               r = tbl_radius[k];
               if ($urandom_range(0, 4) != 0 && r > 0 && r < (64'd1 << 30)) begin
                  off_x = longint'($urandom_range(0, 2 * r)) - r;
                  off_y = longint'($urandom_range(0, 2 * r)) - r;
                  it.pos_x = 32'(longint'(signed'(tbl_x[k])) + off_x);
                  it.pos_y = 32'(longint'(signed'(tbl_y[k])) + off_y);
               end
            end
            send_item(it);
            sent++;
         end
      end
   endtask

   // Receiver stall pattern, with a long hold when asked.
   initial begin
      int hold_left, mode, mode_left, tick;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = $urandom_range(0, 2) == 0;
               2: rsp_stall = (tick % 5) < 3;
               default: rsp_stall = 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // Compare each result transfer with the oldest expected shade.
   always @(posedge clock) begin
      shade_result_type exp_shade;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_shades.size() == 0) begin
            errors++;
            $display("%0t: unexpected result color=%h depth=%h", $time,
                     rsp_shaded_color, rsp_depth);
         end else begin
            exp_shade = pending_shades.pop_front();
            if (rsp_shaded_color !== exp_shade.color) begin
               errors++;
               $display("%0t: color expected %h actual %h", $time, exp_shade.color,
                        rsp_shaded_color);
            end
            if (rsp_depth !== exp_shade.depth) begin
               errors++;
               $display("%0t: depth expected %h actual %h", $time, exp_shade.depth,
                        rsp_depth);
            end
            if (rsp_out_x !== exp_shade.x) begin
               errors++;
               $display("%0t: x expected %h actual %h", $time, exp_shade.x, rsp_out_x);
            end
            if (rsp_out_y !== exp_shade.y) begin
               errors++;
               $display("%0t: y expected %h actual %h", $time, exp_shade.y, rsp_out_y);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      int idle_cycles;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_passthrough();
      test_light_extremes();
      test_too_many_lights();
      test_back_pressure();
      test_random_traffic();
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0 && pending_shades.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
